>>> rtl/windowed_rms_meter_defines.svh
// Assertion macros for the windowed RMS meter.
`ifndef WINDOWED_RMS_METER_DEFINES_SVH
`define WINDOWED_RMS_METER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define WRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/wrm_pkg.sv
package wrm_pkg;

	// Fixed field widths
	localparam int unsigned SAMPLE_BITS    = 16;
	localparam int unsigned GOAL_BITS      = 31;
	localparam int unsigned SUM_OUT_BITS   = 61;
	localparam int unsigned MEAN_BITS      = 31;
	localparam int unsigned RMS_BITS       = 16;
	localparam int unsigned COUNT_BITS_DEF = 31;

	// Sequencer step counts
	localparam int unsigned STEP_BITS  = 5;
	localparam int unsigned DIV_STEPS  = MEAN_BITS;
	localparam int unsigned SQRT_STEPS = RMS_BITS;

	// Goal value that disarms the window
	localparam logic [GOAL_BITS-1:0] IDLE_GOAL = 31'd2000000000;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_GOAL   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_PREP,
		ST_DIV,
		ST_SQRT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t                           operation;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [GOAL_BITS-1:0]          goal;
	} in_word_t;

	typedef struct packed {
		logic [SUM_OUT_BITS-1:0] sum_of_squares;
		logic [GOAL_BITS-1:0]    sample_count;
		logic [MEAN_BITS-1:0]    mean_square;
		logic [RMS_BITS-1:0]     rms;
	} out_word_t;

endpackage

>>> rtl/wrm_alu.sv
// Shared compare-and-subtract unit for restoring divide and square root steps.
module wrm_alu #(
	parameter int unsigned W = 32
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         ge
);

	logic [W:0] full;

	// Subtract with one guard bit; no borrow means a >= b
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[W-1:0];
	assign ge   = ~full[W];

endmodule

>>> rtl/windowed_rms_meter.sv
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid / in_ready     | wrm_pkg::in_word_t (operation, sample, goal)
// out     | output    | out_valid / out_ready   | wrm_pkg::out_word_t (sum, count, mean, rms)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_data: continuous_mode
//
// A sample passes through accept, square and accumulate; a goal word with no report ends at accept.
// A report adds a prep step, 31 divide steps, 16 square root steps and an emit step;
// the divide and square root steps all run on the one shared compare-and-subtract unit.
// Reset clears sum and count, sets the goal to 2000000000 and continuous mode to 1.
// A report waits in the emit state while the output register still holds an untaken word.
`include "windowed_rms_meter_defines.svh"

module windowed_rms_meter #(
	parameter int unsigned COUNT_BITS = wrm_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wrm_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wrm_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	localparam int unsigned SUM_BITS = COUNT_BITS + 30;
	localparam int unsigned AW       = (COUNT_BITS + 1 > 19) ? COUNT_BITS + 1 : 19;

	wrm_pkg::state_t state_q, state_d;

	logic                              cont_q;
	logic [wrm_pkg::GOAL_BITS-1:0]     goal_q;
	logic [SUM_BITS-1:0]               sum_q;
	logic [COUNT_BITS-1:0]             cnt_q;
	logic                              out_valid_q;
	wrm_pkg::out_word_t                out_q;

	wrm_pkg::in_word_t                 item_q;
	logic [30:0]                       sq_q;
	logic [AW-1:0]                     rem_q;
	logic [wrm_pkg::MEAN_BITS-1:0]     dq_q;
	logic [2*wrm_pkg::RMS_BITS-1:0]    shf_q;
	logic [wrm_pkg::RMS_BITS-1:0]      root_q;
	logic [wrm_pkg::STEP_BITS-1:0]     step_q;

	logic                              in_acc;
	logic                              emit_go;
	logic                              cnt_full;
	logic                              goal_report;
	logic                              goal_hit;
	logic [COUNT_BITS-1:0]             cnt_inc;
	logic [wrm_pkg::SAMPLE_BITS-1:0]   mag;
	logic [2*wrm_pkg::SAMPLE_BITS-1:0] prod;
	logic [AW-1:0]                     alu_a, alu_b, alu_diff;
	logic                              alu_ge;

	wrm_alu #(
		.W(AW)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// Status decode
	assign in_acc      = in_valid && in_ready;
	assign cnt_full    = (cnt_q == {COUNT_BITS{1'b1}});
	assign goal_report = cont_q && (cnt_q != '0);
	assign cnt_inc     = cnt_q + 1'b1;
	assign goal_hit    = (wrm_pkg::GOAL_BITS'(cnt_inc) == goal_q);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;

	// Magnitude and square of the held sample
	assign mag  = item_q.sample[wrm_pkg::SAMPLE_BITS-1] ?
		wrm_pkg::SAMPLE_BITS'(-item_q.sample) : wrm_pkg::SAMPLE_BITS'(item_q.sample);
	assign prod = mag * mag;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wrm_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_data.operation == wrm_pkg::OP_GOAL) begin
						state_d = goal_report ? wrm_pkg::ST_PREP : wrm_pkg::ST_IDLE;
					end else if (!cnt_full) begin
						state_d = wrm_pkg::ST_SQUARE;
					end
				end
			end
			wrm_pkg::ST_SQUARE: state_d = wrm_pkg::ST_ACCUM;
			wrm_pkg::ST_ACCUM:  state_d = goal_hit ? wrm_pkg::ST_PREP : wrm_pkg::ST_IDLE;
			wrm_pkg::ST_PREP:   state_d = wrm_pkg::ST_DIV;
			wrm_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_d = wrm_pkg::ST_SQRT;
				end
			end
			wrm_pkg::ST_SQRT: begin
				if (step_q == '0) begin
					state_d = wrm_pkg::ST_EMIT;
				end
			end
			wrm_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = wrm_pkg::ST_IDLE;
				end
			end
			default: state_d = wrm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and shared unit operands
	always_comb begin
		in_ready = 1'b0;
		emit_go  = 1'b0;
		alu_a    = '0;
		alu_b    = '0;
		case (state_q)
			wrm_pkg::ST_IDLE: in_ready = 1'b1;
			wrm_pkg::ST_DIV: begin
				alu_a = {rem_q[AW-2:0], dq_q[wrm_pkg::MEAN_BITS-1]};
				alu_b = AW'(cnt_q);
			end
			wrm_pkg::ST_SQRT: begin
				alu_a = {rem_q[AW-3:0], shf_q[2*wrm_pkg::RMS_BITS-1 -: 2]};
				alu_b = AW'({root_q, 2'b01});
			end
			wrm_pkg::ST_EMIT: emit_go = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wrm_pkg::ST_IDLE;
			cont_q      <= 1'b1;
			goal_q      <= wrm_pkg::IDLE_GOAL;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cont_q <= cfg_data;
			end
			// Hold the output word until taken; load a new report over a taken one
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Goal word with no pending report: restart the window at once
			if (state_q == wrm_pkg::ST_IDLE && in_acc &&
				in_data.operation == wrm_pkg::OP_GOAL && !goal_report) begin
				sum_q  <= '0;
				cnt_q  <= '0;
				goal_q <= in_data.goal;
			end
			// Accumulate one square
			if (state_q == wrm_pkg::ST_ACCUM) begin
				sum_q <= sum_q + SUM_BITS'(sq_q);
				cnt_q <= cnt_inc;
			end
			// Deliver report, clear window, rearm or disarm goal
			if (emit_go) begin
				sum_q <= '0;
				cnt_q <= '0;
				if (item_q.operation == wrm_pkg::OP_GOAL) begin
					goal_q <= item_q.goal;
				end else if (!cont_q) begin
					goal_q <= wrm_pkg::IDLE_GOAL;
				end
			end
		end
	end

	// Working registers: held input word, square, divide and square root, output word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		case (state_q)
			wrm_pkg::ST_SQUARE: sq_q <= prod[30:0];
			wrm_pkg::ST_PREP: begin
				rem_q  <= AW'(sum_q >> wrm_pkg::MEAN_BITS);
				dq_q   <= sum_q[wrm_pkg::MEAN_BITS-1:0];
				step_q <= wrm_pkg::STEP_BITS'(wrm_pkg::DIV_STEPS - 1);
			end
			wrm_pkg::ST_DIV: begin
				dq_q <= {dq_q[wrm_pkg::MEAN_BITS-2:0], alu_ge};
				// Last quotient bit: hand the mean to the root stage
				if (step_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
					shf_q  <= {1'b0, dq_q[wrm_pkg::MEAN_BITS-2:0], alu_ge};
					step_q <= wrm_pkg::STEP_BITS'(wrm_pkg::SQRT_STEPS - 1);
				end else begin
					rem_q  <= alu_ge ? alu_diff : alu_a;
					step_q <= step_q - 1'b1;
				end
			end
			wrm_pkg::ST_SQRT: begin
				rem_q  <= alu_ge ? alu_diff : alu_a;
				root_q <= {root_q[wrm_pkg::RMS_BITS-2:0], alu_ge};
				shf_q  <= {shf_q[2*wrm_pkg::RMS_BITS-3:0], 2'b00};
				step_q <= step_q - 1'b1;
			end
			default: begin
				step_q <= step_q;
			end
		endcase
		if (emit_go) begin
			out_q.sum_of_squares <= wrm_pkg::SUM_OUT_BITS'(sum_q);
			out_q.sample_count   <= wrm_pkg::GOAL_BITS'(cnt_q);
			out_q.mean_square    <= dq_q;
			out_q.rms            <= root_q;
		end
	end

	// Checks
	`WRM_ASSERT_SAME(a_count_below_goal, clk, arst_n, (state_q == wrm_pkg::ST_IDLE && goal_q != '0), (wrm_pkg::GOAL_BITS'(cnt_q) != goal_q), "window count reached goal without a report")
	`WRM_ASSERT_SAME(a_div_rem_bound, clk, arst_n, (state_q == wrm_pkg::ST_DIV), (rem_q < AW'(cnt_q)), "divide remainder not below count")
	`WRM_ASSERT_NEXT(a_emit_clears, clk, arst_n, emit_go, (out_valid_q && cnt_q == '0 && sum_q == '0), "report did not clear the window")

endmodule
